// File: rtl/core/tptc_pkg.sv
// Shared constants and controller/datapath interface types for the TLB translator.
// Used by every module in rtl/core; depends on nothing else.
`default_nettype none
package tptc_pkg;

    localparam int VA_W          = 16;
    localparam int PA_W          = 12;
    localparam int CNT_W         = 32;

    localparam int TLB_ENTRIES   = 8;
    localparam int CACHE_ENTRIES = 16;
    localparam int FRAME_COUNT   = 16;
    localparam int OFFSET_BITS   = 8;

    typedef struct packed {
        logic init_en;
        logic accept;
        logic resolve;
        logic finish;
    } tptc_cmd_t;

    typedef struct packed {
        logic init_last;
    } tptc_status_t;

endpackage
`default_nettype wire

// File: rtl/core/tptc_ctrl.sv
// Controller for the translator: sequences the page table sweep, each item's
// lookup steps and the output handshake. Depends on tptc_pkg.
`default_nettype none
module tptc_ctrl
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    input  wire tptc_pkg::tptc_status_t status,
    output tptc_pkg::tptc_cmd_t        cmd
);

    typedef enum logic [1:0]
    {
        ST_INIT,
        ST_IDLE,
        ST_LOOK,
        ST_CACHE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;
    logic   take;

    assign out_free = !out_valid_reg || !out_stall;
    assign take     = (state_reg == ST_IDLE) || ((state_reg == ST_CACHE) && out_free);

    always_comb
    begin
        cmd.init_en = (state_reg == ST_INIT);
        cmd.resolve = (state_reg == ST_LOOK);
        cmd.finish  = (state_reg == ST_CACHE) && out_free;
        cmd.accept  = in_valid && take;
    end

    assign in_stall  = !take;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_INIT:
            begin
                if (status.init_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                state_next = ST_CACHE;
            end
            ST_CACHE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = in_valid ? ST_LOOK : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/tptc_dp.sv
// Datapath for the translator: TLB, page table memory, frame cache tags,
// statistics counters and result registers. Depends on tptc_pkg.
`default_nettype none
module tptc_dp
#(
    parameter int TLB_ENTRIES   = tptc_pkg::TLB_ENTRIES,
    parameter int CACHE_ENTRIES = tptc_pkg::CACHE_ENTRIES,
    parameter int FRAME_COUNT   = tptc_pkg::FRAME_COUNT,
    parameter int OFFSET_BITS   = tptc_pkg::OFFSET_BITS
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire tptc_pkg::tptc_cmd_t          cmd,
    output tptc_pkg::tptc_status_t            status,
    input  wire logic [tptc_pkg::VA_W-1:0]    vaddr,
    output logic      [tptc_pkg::PA_W-1:0]    paddr,
    output logic                              tlb_hit,
    output logic                              page_fault,
    output logic                              cache_hit,
    output logic      [tptc_pkg::CNT_W-1:0]   tlb_hit_count,
    output logic      [tptc_pkg::CNT_W-1:0]   tlb_miss_count,
    output logic      [tptc_pkg::CNT_W-1:0]   cache_hit_count,
    output logic      [tptc_pkg::CNT_W-1:0]   cache_miss_count,
    output logic      [tptc_pkg::CNT_W-1:0]   fault_count
);

    localparam int PAGE_W     = tptc_pkg::VA_W - OFFSET_BITS;
    localparam int PAGE_COUNT = 1 << PAGE_W;
    localparam int FRAME_W    = $clog2(FRAME_COUNT);
    localparam int TLB_IDX_W  = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
    localparam int CACHE_IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int RAW_W      = FRAME_W + OFFSET_BITS;

    // Each page table word holds a valid bit above the frame number.
    logic [FRAME_W:0]           map_mem [PAGE_COUNT];
    logic [FRAME_W:0]           map_rd_reg;
    logic                       map_we;
    logic [PAGE_W-1:0]          map_waddr;
    logic [FRAME_W:0]           map_wdata;

    logic [PAGE_W-1:0]          init_addr_reg;
    logic [FRAME_W-1:0]         init_mod_reg;

    logic [PAGE_W-1:0]          page_reg;
    logic [OFFSET_BITS-1:0]     offset_reg;
    logic [FRAME_W-1:0]         frame_reg;
    logic                       thit_reg;
    logic                       fault_reg;

    logic                       tlb_valid_reg [TLB_ENTRIES];
    logic [PAGE_W-1:0]          tlb_tag_reg   [TLB_ENTRIES];
    logic [FRAME_W-1:0]         tlb_pfn_reg   [TLB_ENTRIES];
    logic [TLB_IDX_W-1:0]       tlb_ptr_reg;

    logic                       cache_valid_reg [CACHE_ENTRIES];
    logic [FRAME_W-1:0]         cache_tag_reg   [CACHE_ENTRIES];
    logic [CACHE_IDX_W-1:0]     cache_ptr_reg;

    logic [tptc_pkg::CNT_W-1:0] cnt_tlb_hit_reg;
    logic [tptc_pkg::CNT_W-1:0] cnt_tlb_miss_reg;
    logic [tptc_pkg::CNT_W-1:0] cnt_cache_hit_reg;
    logic [tptc_pkg::CNT_W-1:0] cnt_cache_miss_reg;
    logic [tptc_pkg::CNT_W-1:0] cnt_fault_reg;

    logic [tptc_pkg::PA_W-1:0]  pa_reg;
    logic                       out_thit_reg;
    logic                       out_fault_reg;
    logic                       out_chit_reg;

    logic [TLB_ENTRIES-1:0]     tlb_match;
    logic [FRAME_W-1:0]         tlb_sel_frame;
    logic                       tlb_any;
    logic                       map_valid;
    logic                       fault_now;
    logic [CACHE_ENTRIES-1:0]   cache_match;
    logic                       chit_now;
    logic [RAW_W-1:0]           pa_raw;

    assign status.init_last = (init_addr_reg == {PAGE_W{1'b1}});

    // Page table: swept once after reset, then read at accept, written on a fault.
    always_comb
    begin
        map_valid = map_rd_reg[FRAME_W];
        fault_now = !tlb_any && !map_valid;
        map_we    = cmd.init_en || (cmd.resolve && fault_now);
        if (cmd.init_en)
        begin
            map_waddr = init_addr_reg;
            map_wdata = {(32'(init_addr_reg) < FRAME_COUNT), init_mod_reg};
        end
        else
        begin
            map_waddr = page_reg;
            map_wdata = {1'b1, map_rd_reg[FRAME_W-1:0]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[map_waddr] <= map_wdata;
        end
        if (cmd.accept)
        begin
            map_rd_reg <= map_mem[vaddr[tptc_pkg::VA_W-1:OFFSET_BITS]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_addr_reg <= '0;
            init_mod_reg  <= '0;
        end
        else if (cmd.init_en)
        begin
            init_addr_reg <= init_addr_reg + 1'b1;
            if (32'(init_mod_reg) == FRAME_COUNT - 1)
            begin
                init_mod_reg <= '0;
            end
            else
            begin
                init_mod_reg <= init_mod_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        tlb_sel_frame = '0;
        for (int i = 0; i < TLB_ENTRIES; i++)
        begin
            tlb_match[i] = tlb_valid_reg[i] && (tlb_tag_reg[i] == page_reg);
        end
        for (int i = TLB_ENTRIES - 1; i >= 0; i--)
        begin
            if (tlb_match[i])
            begin
                tlb_sel_frame = tlb_pfn_reg[i];
            end
        end
        tlb_any = |tlb_match;
    end

    always_comb
    begin
        for (int i = 0; i < CACHE_ENTRIES; i++)
        begin
            cache_match[i] = cache_valid_reg[i] && (cache_tag_reg[i] == frame_reg);
        end
        chit_now = |cache_match;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            page_reg   <= vaddr[tptc_pkg::VA_W-1:OFFSET_BITS];
            offset_reg <= vaddr[OFFSET_BITS-1:0];
        end
        if (cmd.resolve)
        begin
            thit_reg  <= tlb_any;
            fault_reg <= fault_now;
            frame_reg <= tlb_any ? tlb_sel_frame : map_rd_reg[FRAME_W-1:0];
        end
        if (cmd.resolve && !tlb_any)
        begin
            tlb_tag_reg[tlb_ptr_reg] <= page_reg;
            tlb_pfn_reg[tlb_ptr_reg] <= map_rd_reg[FRAME_W-1:0];
        end
        if (cmd.finish && !chit_now)
        begin
            cache_tag_reg[cache_ptr_reg] <= frame_reg;
        end
        if (cmd.finish)
        begin
            pa_reg        <= tptc_pkg::PA_W'(pa_raw);
            out_thit_reg  <= thit_reg;
            out_fault_reg <= fault_reg;
            out_chit_reg  <= chit_now;
        end
    end

    assign pa_raw = {frame_reg, offset_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TLB_ENTRIES; i++)
            begin
                tlb_valid_reg[i] <= 1'b0;
            end
            for (int i = 0; i < CACHE_ENTRIES; i++)
            begin
                cache_valid_reg[i] <= 1'b0;
            end
            tlb_ptr_reg   <= '0;
            cache_ptr_reg <= '0;
        end
        else
        begin
            if (cmd.resolve && !tlb_any)
            begin
                tlb_valid_reg[tlb_ptr_reg] <= 1'b1;
                if (32'(tlb_ptr_reg) == TLB_ENTRIES - 1)
                begin
                    tlb_ptr_reg <= '0;
                end
                else
                begin
                    tlb_ptr_reg <= tlb_ptr_reg + 1'b1;
                end
            end
            if (cmd.finish && !chit_now)
            begin
                cache_valid_reg[cache_ptr_reg] <= 1'b1;
                if (32'(cache_ptr_reg) == CACHE_ENTRIES - 1)
                begin
                    cache_ptr_reg <= '0;
                end
                else
                begin
                    cache_ptr_reg <= cache_ptr_reg + 1'b1;
                end
            end
        end
    end

    // The counters change only when a result is loaded, so they drive the ports directly.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_tlb_hit_reg    <= '0;
            cnt_tlb_miss_reg   <= '0;
            cnt_cache_hit_reg  <= '0;
            cnt_cache_miss_reg <= '0;
            cnt_fault_reg      <= '0;
        end
        else if (cmd.finish)
        begin
            if (thit_reg && !(&cnt_tlb_hit_reg))
            begin
                cnt_tlb_hit_reg <= cnt_tlb_hit_reg + 1'b1;
            end
            if (!thit_reg && !(&cnt_tlb_miss_reg))
            begin
                cnt_tlb_miss_reg <= cnt_tlb_miss_reg + 1'b1;
            end
            if (chit_now && !(&cnt_cache_hit_reg))
            begin
                cnt_cache_hit_reg <= cnt_cache_hit_reg + 1'b1;
            end
            if (!chit_now && !(&cnt_cache_miss_reg))
            begin
                cnt_cache_miss_reg <= cnt_cache_miss_reg + 1'b1;
            end
            if (fault_reg && !(&cnt_fault_reg))
            begin
                cnt_fault_reg <= cnt_fault_reg + 1'b1;
            end
        end
    end

    assign paddr            = pa_reg;
    assign tlb_hit          = out_thit_reg;
    assign page_fault       = out_fault_reg;
    assign cache_hit        = out_chit_reg;
    assign tlb_hit_count    = cnt_tlb_hit_reg;
    assign tlb_miss_count   = cnt_tlb_miss_reg;
    assign cache_hit_count  = cnt_cache_hit_reg;
    assign cache_miss_count = cnt_cache_miss_reg;
    assign fault_count      = cnt_fault_reg;

endmodule
`default_nettype wire

// File: rtl/core/tlb_page_table_cache_translator.sv
// Top level of the TLB address translator: controller plus datapath.
// Depends on tptc_pkg, tptc_ctrl and tptc_dp.
//
// Each item on the input channel is a 16-bit virtual address. The block looks
// the page up in a FIFO-filled TLB, falls back to the page table memory on a
// miss, fills faulting pages, checks the frame against a tag-only FIFO cache
// and returns one result item per input item with the physical address, the
// hit and fault flags and five saturating event counters.
// An item is taken when in_valid is high and in_stall is low; a result is
// taken when out_valid is high and out_stall is low.
// out_valid rises once an accepted item has passed its lookup and cache steps;
// the page table memory is read at accept and written back on the next cycle
// on a fault, and the cache tags are checked on the one after that, when the
// next item can already be taken.
// After reset the page table memory is swept once, one entry per cycle, over
// all 2**(16 - OFFSET_BITS) entries (256 by default); in_stall stays high
// until the sweep is done. A stalled result holds the next item in its cache
// step and keeps in_stall high until the result is taken.
`default_nettype none
module tlb_page_table_cache_translator
#(
    parameter int TLB_ENTRIES   = tptc_pkg::TLB_ENTRIES,
    parameter int CACHE_ENTRIES = tptc_pkg::CACHE_ENTRIES,
    parameter int FRAME_COUNT   = tptc_pkg::FRAME_COUNT,
    parameter int OFFSET_BITS   = tptc_pkg::OFFSET_BITS
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [tptc_pkg::VA_W-1:0]    vaddr,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic      [tptc_pkg::PA_W-1:0]    paddr,
    output logic                              tlb_hit,
    output logic                              page_fault,
    output logic                              cache_hit,
    output logic      [tptc_pkg::CNT_W-1:0]   tlb_hit_count,
    output logic      [tptc_pkg::CNT_W-1:0]   tlb_miss_count,
    output logic      [tptc_pkg::CNT_W-1:0]   cache_hit_count,
    output logic      [tptc_pkg::CNT_W-1:0]   cache_miss_count,
    output logic      [tptc_pkg::CNT_W-1:0]   fault_count
);

    tptc_pkg::tptc_cmd_t    cmd;
    tptc_pkg::tptc_status_t status;

    tptc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    tptc_dp
    #(
        .TLB_ENTRIES   (TLB_ENTRIES),
        .CACHE_ENTRIES (CACHE_ENTRIES),
        .FRAME_COUNT   (FRAME_COUNT),
        .OFFSET_BITS   (OFFSET_BITS)
    )
    u_dp
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .vaddr            (vaddr),
        .paddr            (paddr),
        .tlb_hit          (tlb_hit),
        .page_fault       (page_fault),
        .cache_hit        (cache_hit),
        .tlb_hit_count    (tlb_hit_count),
        .tlb_miss_count   (tlb_miss_count),
        .cache_hit_count  (cache_hit_count),
        .cache_miss_count (cache_miss_count),
        .fault_count      (fault_count)
    );

endmodule
`default_nettype wire

// File: rtl/core/tptc_checker.sv
// Port-level checks for the TLB address translator, bound to its top level.
// Depends on tptc_pkg.
`default_nettype none
module tptc_checker
(
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       in_valid,
    input wire logic                       in_stall,
    input wire logic                       out_valid,
    input wire logic                       out_stall,
    input wire logic [tptc_pkg::PA_W-1:0]  paddr,
    input wire logic                       tlb_hit,
    input wire logic                       page_fault,
    input wire logic [tptc_pkg::CNT_W-1:0] fault_count
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("Stalled result item was dropped.");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(paddr) && $stable(fault_count))
        else $error("Stalled result item changed.");

    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("Two items accepted in consecutive cycles.");

    a_hit_no_fault: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(tlb_hit && page_fault))
        else $error("A TLB hit reported a page fault.");

endmodule

bind tlb_page_table_cache_translator tptc_checker u_tptc_checker (.*);
`default_nettype wire

// File: verif/tb.sv
// Testbench for tlb_page_table_cache_translator: directed and random address items.
// Results are checked against a built-in translation predictor or typed directed rows; depends on tptc_pkg.
`timescale 1ns / 100ps

module tb;

    localparam int VA_W          = tptc_pkg::VA_W;
    localparam int PA_W          = tptc_pkg::PA_W;
    localparam int CNT_W         = tptc_pkg::CNT_W;
    localparam int TLB_ENTRIES   = tptc_pkg::TLB_ENTRIES;
    localparam int CACHE_ENTRIES = tptc_pkg::CACHE_ENTRIES;
    localparam int FRAME_COUNT   = tptc_pkg::FRAME_COUNT;
    localparam int OFFSET_BITS   = tptc_pkg::OFFSET_BITS;

    localparam int PAGE_W    = VA_W - OFFSET_BITS;
    localparam int PAGES     = 1 << PAGE_W;
    localparam int FRAME_W   = $clog2(FRAME_COUNT);
    localparam int RAND_ITEMS = 1000;
    localparam int HOT_PAGES  = 12;

    typedef enum int {
        STAT_TLB_HIT,
        STAT_TLB_MISS,
        STAT_CACHE_HIT,
        STAT_CACHE_MISS,
        STAT_FAULT,
        STAT_NUM
    } stat_t;

    typedef struct packed {
        logic [PA_W-1:0]  pa;
        logic             tlb_hit;
        logic             fault;
        logic             cache_hit;
        logic [CNT_W-1:0] n_tlb_hit;
        logic [CNT_W-1:0] n_tlb_miss;
        logic [CNT_W-1:0] n_cache_hit;
        logic [CNT_W-1:0] n_cache_miss;
        logic [CNT_W-1:0] n_fault;
    } xlat_t;

    typedef struct packed {
        logic [VA_W-1:0] va;
        logic            typed;
        xlat_t           res;
    } dir_row_t;

    localparam int DIR_ROWS = 22;
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        '{16'h0000, 1'b1,
          '{12'h000, 1'b0, 1'b0, 1'b0, 32'd0, 32'd1, 32'd0, 32'd1, 32'd0}},
        '{16'h00FF, 1'b1,
          '{12'h0FF, 1'b1, 1'b0, 1'b1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd0}},
        '{16'hFFFF, 1'b1,
          '{12'hFFF, 1'b0, 1'b1, 1'b0, 32'd1, 32'd2, 32'd1, 32'd2, 32'd1}},
        '{16'h0F80, 1'b1,
          '{12'hF80, 1'b0, 1'b0, 1'b1, 32'd1, 32'd3, 32'd2, 32'd2, 32'd1}},
        '{16'h10AB, 1'b1,
          '{12'h0AB, 1'b0, 1'b1, 1'b1, 32'd1, 32'd4, 32'd3, 32'd2, 32'd2}},
        '{16'h0112, 1'b0, '0},
        '{16'h2234, 1'b0, '0},
        '{16'h3356, 1'b0, '0},
        '{16'h4478, 1'b0, '0},
        '{16'h559A, 1'b0, '0},
        '{16'h66BC, 1'b0, '0},
        '{16'h77DE, 1'b0, '0},
        '{16'h88F0, 1'b0, '0},
        '{16'h9901, 1'b0, '0},
        '{16'hAA23, 1'b0, '0},
        '{16'hBB45, 1'b0, '0},
        '{16'hCC67, 1'b0, '0},
        '{16'hDD89, 1'b0, '0},
        '{16'hEEAB, 1'b0, '0},
        '{16'hFF00, 1'b0, '0},
        '{16'h0000, 1'b0, '0},
        '{16'h10FF, 1'b0, '0}
    };

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [VA_W-1:0]     vaddr;
    logic                out_valid;
    logic                out_stall;
    logic [PA_W-1:0]     paddr;
    logic                tlb_hit;
    logic                page_fault;
    logic                cache_hit;
    logic [CNT_W-1:0]    tlb_hit_count;
    logic [CNT_W-1:0]    tlb_miss_count;
    logic [CNT_W-1:0]    cache_hit_count;
    logic [CNT_W-1:0]    cache_miss_count;
    logic [CNT_W-1:0]    fault_count;

    bit                  quiet = 1'b0;
    int                  err_count = 0;
    xlat_t               pending_xlat [$];

    logic                tlb_vld   [TLB_ENTRIES];
    logic [PAGE_W-1:0]   tlb_vpn   [TLB_ENTRIES];
    logic [FRAME_W-1:0]  tlb_pfn   [TLB_ENTRIES];
    int                  tlb_ptr;
    logic                pt_vld    [PAGES];
    logic [FRAME_W-1:0]  pt_frame  [PAGES];
    logic                ctag_vld  [CACHE_ENTRIES];
    logic [FRAME_W-1:0]  ctag      [CACHE_ENTRIES];
    int                  ctag_ptr;
    logic [CNT_W-1:0]    stats     [STAT_NUM];

    tlb_page_table_cache_translator u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .vaddr            (vaddr),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .paddr            (paddr),
        .tlb_hit          (tlb_hit),
        .page_fault       (page_fault),
        .cache_hit        (cache_hit),
        .tlb_hit_count    (tlb_hit_count),
        .tlb_miss_count   (tlb_miss_count),
        .cache_hit_count  (cache_hit_count),
        .cache_miss_count (cache_miss_count),
        .fault_count      (fault_count)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void clear_translation_state();
        for (int i = 0; i < TLB_ENTRIES; i++)
        begin
            tlb_vld[i] = 1'b0;
            tlb_vpn[i] = '0;
            tlb_pfn[i] = '0;
        end
        tlb_ptr = 0;
        for (int p = 0; p < PAGES; p++)
        begin
            pt_vld[p]   = (p < FRAME_COUNT);
            pt_frame[p] = (p < FRAME_COUNT) ? FRAME_W'(p) : '0;
        end
        for (int i = 0; i < CACHE_ENTRIES; i++)
        begin
            ctag_vld[i] = 1'b0;
            ctag[i]     = '0;
        end
        ctag_ptr = 0;
        for (int k = 0; k < STAT_NUM; k++)
            stats[k] = '0;
    endfunction

    function automatic void bump(stat_t k);
        if (stats[k] != '1)
            stats[k] = stats[k] + 1'b1;
    endfunction

    function automatic xlat_t translate(input logic [VA_W-1:0] va);
        logic [PAGE_W-1:0]  page;
        logic [FRAME_W-1:0] frame;
        xlat_t              r;
        int                 hit_idx;
        page    = va[VA_W-1:OFFSET_BITS];
        frame   = '0;
        r       = '0;
        hit_idx = -1;
        for (int i = 0; i < TLB_ENTRIES; i++)
            if (hit_idx < 0 && tlb_vld[i] && tlb_vpn[i] == page)
                hit_idx = i;
        if (hit_idx >= 0)
        begin
            r.tlb_hit = 1'b1;
            frame = tlb_pfn[hit_idx];
            bump(STAT_TLB_HIT);
        end
        else
        begin
            bump(STAT_TLB_MISS);
            if (pt_vld[page])
                frame = pt_frame[page];
            else
            begin
                r.fault = 1'b1;
                bump(STAT_FAULT);
                frame = FRAME_W'(page % FRAME_COUNT);
                pt_frame[page] = frame;
                pt_vld[page]   = 1'b1;
            end
            tlb_vld[tlb_ptr] = 1'b1;
            tlb_vpn[tlb_ptr] = page;
            tlb_pfn[tlb_ptr] = frame;
            tlb_ptr = (tlb_ptr + 1 >= TLB_ENTRIES) ? 0 : tlb_ptr + 1;
        end
        for (int i = 0; i < CACHE_ENTRIES; i++)
            if (ctag_vld[i] && ctag[i] == frame)
                r.cache_hit = 1'b1;
        if (r.cache_hit)
            bump(STAT_CACHE_HIT);
        else
        begin
            bump(STAT_CACHE_MISS);
            ctag_vld[ctag_ptr] = 1'b1;
            ctag[ctag_ptr]     = frame;
            ctag_ptr = (ctag_ptr + 1 >= CACHE_ENTRIES) ? 0 : ctag_ptr + 1;
        end
        r.pa = PA_W'((32'(frame) << OFFSET_BITS) | 32'(va[OFFSET_BITS-1:0]));
        r.n_tlb_hit    = stats[STAT_TLB_HIT];
        r.n_tlb_miss   = stats[STAT_TLB_MISS];
        r.n_cache_hit  = stats[STAT_CACHE_HIT];
        r.n_cache_miss = stats[STAT_CACHE_MISS];
        r.n_fault      = stats[STAT_FAULT];
        return r;
    endfunction

    task automatic send_address(input logic [VA_W-1:0] va, input bit typed, input xlat_t given);
        xlat_t predicted;
        while (!quiet && $urandom_range(99) < 30)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        vaddr    <= va;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        predicted = translate(va);
        pending_xlat.push_back(typed ? given : predicted);
    endtask

    task automatic hold_until_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_xlat.size() != 0);
    endtask

    function automatic void check_field(input string what, input logic [CNT_W-1:0] want,
                                        input logic [CNT_W-1:0] got);
        if (got !== want)
        begin
            err_count++;
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
        end
    endfunction

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            out_stall <= !quiet && ($urandom_range(99) < 30);
        end
    end

    always @(posedge clk)
    begin
        xlat_t want;
        if (rst_n && out_valid === 1'b1 && !out_stall)
        begin
            if (pending_xlat.size() == 0)
            begin
                err_count++;
                $display("%0t: result with no item waiting: expected none, actual pa %0h",
                         $time, paddr);
            end
            else
            begin
                want = pending_xlat.pop_front();
                check_field("paddr", CNT_W'(want.pa), CNT_W'(paddr));
                check_field("tlb_hit", CNT_W'(want.tlb_hit), CNT_W'(tlb_hit));
                check_field("page_fault", CNT_W'(want.fault), CNT_W'(page_fault));
                check_field("cache_hit", CNT_W'(want.cache_hit), CNT_W'(cache_hit));
                check_field("tlb_hit_count", want.n_tlb_hit, tlb_hit_count);
                check_field("tlb_miss_count", want.n_tlb_miss, tlb_miss_count);
                check_field("cache_hit_count", want.n_cache_hit, cache_hit_count);
                check_field("cache_miss_count", want.n_cache_miss, cache_miss_count);
                check_field("fault_count", want.n_fault, fault_count);
            end
        end
    end

    initial
    begin
        logic [PAGE_W-1:0] hot [HOT_PAGES];
        logic [PAGE_W-1:0] page;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        vaddr    = '0;
        clear_translation_state();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
            send_address(DIRECTED[i].va, DIRECTED[i].typed, DIRECTED[i].res);
        hold_until_drained();

        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            if (n % 100 == 0)
                for (int k = 0; k < HOT_PAGES; k++)
                    hot[k] = PAGE_W'($urandom);
            quiet = (n >= 400 && n < 550);
            if (n == 700)
                hold_until_drained();
            if ($urandom_range(99) < 60)
                page = hot[$urandom_range(HOT_PAGES - 1)];
            else
                page = PAGE_W'($urandom);
            send_address({page, OFFSET_BITS'($urandom)}, 1'b0, '0);
        end
        quiet = 1'b0;
        in_valid <= 1'b0;

        while (pending_xlat.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (err_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/tptc_pkg.sv
rtl/core/tptc_ctrl.sv
rtl/core/tptc_dp.sv
rtl/core/tlb_page_table_cache_translator.sv
rtl/core/tptc_checker.sv
verif/tb.sv
